>>> sv/lz77_type10_decompressor_unit_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the type 10 LZ77 decompressor
// Immediate-implication and next-cycle-implication property wrappers.
// ------------------------------------------------------------------------
`ifndef LZ77_TYPE10_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ77_TYPE10_DECOMPRESSOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LZT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define LZT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LZT_ASSERT_IMP(label, ante, cons, msg)
`define LZT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> sv/lzt_pkg.sv
// ------------------------------------------------------------------------
// Type 10 LZ77 decompressor package
// Sequencer states and stream format constants.
// ------------------------------------------------------------------------
package lzt_pkg;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY
	} state_t;

	// Header byte positions; byte zero is the type byte and is ignored.
	localparam logic [1:0] HDR_TYPE    = 2'd0;
	localparam logic [1:0] HDR_SIZE_LO = 2'd1;
	localparam logic [1:0] HDR_SIZE_MI = 2'd2;
	localparam logic [1:0] HDR_SIZE_HI = 2'd3;

	localparam int unsigned THRESHOLD   = 2;
	localparam logic [3:0]  GROUP_UNITS = 4'd8;
	localparam logic [7:0]  FILL_BYTE   = 8'hff;
	localparam logic [7:0]  ZERO_BYTE   = 8'h00;

endpackage

>>> sv/lzt_if.sv
// ------------------------------------------------------------------------
// Type 10 LZ77 decompressor channels
// Valid/ready channels for compressed input and decompressed output.
// ------------------------------------------------------------------------
interface lzt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       stream_done;

	modport source (output valid, output out_byte, output last_of_run,
		output stream_done, input ready);
	modport sink   (input valid, input out_byte, input last_of_run,
		input stream_done, output ready);
endinterface

>>> sv/lz77_type10_decompressor_unit.sv
// ------------------------------------------------------------------------
// Type 10 LZ77 decompressor unit
// Streams compressed bytes in and decompressed bytes out via a 4 KiB ring.
// ------------------------------------------------------------------------
//
//  Channel        Side  Payload                              Per transaction
//  compressed     in    in_byte[7:0]                         one stream byte
//  decompressed   out   out_byte[7:0], last_of_run,          one output byte
//                       stream_done
//
// Header, flag, first token and literal bytes are taken without leaving the idle state.
// A token's second byte starts a copy of 3 to 18 bytes, fed by the single read port
// of the history ring at one byte a cycle while the output is not stalled.
// After reset the ring is swept once, one entry a cycle, over all RING_SIZE
// entries (4096), during which no input is accepted.
// Before the declared size is reached a stalled output holds the copy in place;
// input is taken only when idle and the output register is free.

`include "lz77_type10_decompressor_unit_macros.svh"

module lz77_type10_decompressor_unit #(
	parameter int unsigned RING_SIZE = 4096,
	parameter int unsigned MAX_MATCH = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	lzt_in_if.sink     compressed,
	lzt_out_if.source  decompressed
);

	localparam int unsigned RING_AW = $clog2(RING_SIZE);
	localparam int unsigned LEN_W   = $clog2(MAX_MATCH + 1);

	lzt_pkg::state_t state_q, state_d;

	logic [7:0]         ring_mem [RING_SIZE];
	logic [7:0]         rd_data_q;
	logic [RING_AW-1:0] rd_addr_q;
	logic [RING_AW-1:0] clr_addr_q;
	logic [RING_AW-1:0] wp_q;

	logic [1:0]         hdr_cnt_q;
	logic               body_q;
	logic               tok2_q;
	logic [7:0]         tok_high_q;
	logic [7:0]         flag_q;
	logic [3:0]         units_q;
	logic [23:0]        declared_q;
	logic [23:0]        produced_q;
	logic [LEN_W-1:0]   cnt_q;
	logic               off_zero_q;
	logic               first_q;
	logic [7:0]         last_q;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               out_done_q;

	logic               out_free, acc;
	logic               is_hdr, is_tok2, is_flag, is_lit, is_tok1;
	logic               emit_ok, emit_done, copy_go, cnt_last;
	logic [11:0]        offset;
	logic [RING_AW-1:0] copy_base;
	logic [7:0]         copy_data;

	logic               mem_we, rd_en, emit_load, emit_last;
	logic [RING_AW-1:0] mem_wa, rd_ra;
	logic [7:0]         mem_wd, emit_byte;

	assign out_free  = !out_valid_q || decompressed.ready;
	assign compressed.ready = (state_q == lzt_pkg::ST_IDLE) && out_free;
	assign acc       = compressed.valid && compressed.ready;

	assign is_hdr    = !body_q;
	assign is_tok2   = body_q && tok2_q;
	assign is_flag   = body_q && !tok2_q && (units_q == 4'd0);
	assign is_lit    = body_q && !tok2_q && (units_q != 4'd0) && !flag_q[7];
	assign is_tok1   = body_q && !tok2_q && (units_q != 4'd0) && flag_q[7];

	assign emit_ok   = produced_q < declared_q;
	assign emit_done = (produced_q + 24'd1) == declared_q;

	assign offset    = {tok_high_q[3:0], compressed.in_byte};
	assign copy_base = wp_q - RING_AW'(offset) - RING_AW'(1);
	// With offset zero each byte after the first repeats the last byte written, held in last_q.
	assign copy_data = (off_zero_q && !first_q) ? last_q : rd_data_q;
	assign copy_go   = (state_q == lzt_pkg::ST_COPY) && (out_free || !emit_ok);
	assign cnt_last  = cnt_q == LEN_W'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzt_pkg::ST_CLEAR: begin
				if (clr_addr_q == RING_AW'(RING_SIZE - 1)) state_d = lzt_pkg::ST_IDLE;
			end
			lzt_pkg::ST_IDLE: begin
				if (acc && is_tok2) state_d = lzt_pkg::ST_COPY;
			end
			lzt_pkg::ST_COPY: begin
				if (copy_go && cnt_last) state_d = lzt_pkg::ST_IDLE;
			end
			default: state_d = lzt_pkg::ST_CLEAR;
		endcase
	end

	// Ring port and output register control.
	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = wp_q;
		mem_wd    = compressed.in_byte;
		rd_en     = 1'b0;
		rd_ra     = rd_addr_q;
		emit_load = 1'b0;
		emit_byte = compressed.in_byte;
		emit_last = 1'b1;
		case (state_q)
			lzt_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_addr_q;
				mem_wd = (clr_addr_q >= RING_AW'(RING_SIZE - MAX_MATCH)) ?
					lzt_pkg::ZERO_BYTE : lzt_pkg::FILL_BYTE;
			end
			lzt_pkg::ST_IDLE: begin
				if (acc && is_lit) begin
					mem_we    = 1'b1;
					emit_load = emit_ok;
				end
				if (acc && is_tok2) begin
					rd_en = 1'b1;
					rd_ra = copy_base;
				end
			end
			lzt_pkg::ST_COPY: begin
				if (copy_go) begin
					mem_we    = 1'b1;
					mem_wd    = copy_data;
					emit_load = emit_ok;
					emit_byte = copy_data;
					emit_last = cnt_last || emit_done;
					if (!cnt_last) begin
						rd_en = 1'b1;
						rd_ra = rd_addr_q + RING_AW'(1);
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) ring_mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_q <= ring_mem[rd_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzt_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			wp_q        <= RING_AW'(RING_SIZE - MAX_MATCH);
			rd_addr_q   <= '0;
			hdr_cnt_q   <= lzt_pkg::HDR_TYPE;
			body_q      <= 1'b0;
			tok2_q      <= 1'b0;
			tok_high_q  <= '0;
			flag_q      <= '0;
			units_q     <= '0;
			declared_q  <= '0;
			produced_q  <= '0;
			cnt_q       <= '0;
			off_zero_q  <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lzt_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + RING_AW'(1);
			if (mem_we && state_q != lzt_pkg::ST_CLEAR) wp_q <= wp_q + RING_AW'(1);
			if (rd_en) rd_addr_q <= rd_ra;
			if (emit_load) produced_q <= produced_q + 24'd1;

			if (acc && is_hdr) begin
				case (hdr_cnt_q)
					lzt_pkg::HDR_SIZE_LO: declared_q[7:0]   <= compressed.in_byte;
					lzt_pkg::HDR_SIZE_MI: declared_q[15:8]  <= compressed.in_byte;
					lzt_pkg::HDR_SIZE_HI: declared_q[23:16] <= compressed.in_byte;
					default: declared_q <= declared_q;
				endcase
				if (hdr_cnt_q == lzt_pkg::HDR_SIZE_HI) body_q <= 1'b1;
				hdr_cnt_q <= hdr_cnt_q + 2'd1;
			end
			if (acc && is_flag) begin
				flag_q  <= compressed.in_byte;
				units_q <= lzt_pkg::GROUP_UNITS;
			end
			if (acc && is_lit) begin
				flag_q  <= {flag_q[6:0], 1'b0};
				units_q <= units_q - 4'd1;
			end
			if (acc && is_tok1) begin
				tok_high_q <= compressed.in_byte;
				tok2_q     <= 1'b1;
			end
			if (acc && is_tok2) begin
				tok2_q     <= 1'b0;
				flag_q     <= {flag_q[6:0], 1'b0};
				if (units_q != 4'd0) units_q <= units_q - 4'd1;
				cnt_q      <= LEN_W'(tok_high_q[7:4]) + LEN_W'(lzt_pkg::THRESHOLD + 1);
				off_zero_q <= offset == 12'd0;
				first_q    <= 1'b1;
			end
			if (copy_go) begin
				cnt_q   <= cnt_q - LEN_W'(1);
				first_q <= 1'b0;
			end

			if (emit_load) out_valid_q <= 1'b1;
			else if (decompressed.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) last_q <= mem_wd;
		if (emit_load) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_done_q <= emit_done;
		end
	end

	assign decompressed.valid       = out_valid_q;
	assign decompressed.out_byte    = out_byte_q;
	assign decompressed.last_of_run = out_last_q;
	assign decompressed.stream_done = out_done_q;

	`LZT_ASSERT_IMP(a_produced_bound, 1'b1, produced_q <= declared_q, "produced count overran size")
	`LZT_ASSERT_IMP(a_done_at_size, out_valid_q && out_done_q, produced_q == declared_q, "done flag before size reached")
	`LZT_ASSERT_NXT(a_copy_count, copy_go && !cnt_last, (state_q == lzt_pkg::ST_COPY) && (cnt_q == $past(cnt_q) - LEN_W'(1)), "copy count slipped")
	`LZT_ASSERT_IMP(a_no_input_busy, state_q != lzt_pkg::ST_IDLE, !compressed.ready, "input taken while sequencer busy")

endmodule

>>> bench/tb_lz77_type10_decompressor_unit.sv
// ------------------------------------------------------------------------
// Testbench for the type 10 LZ77 decompressor unit
// Feeds one compressed stream through the unit. The stream has a header,
// directed extremes, random groups under several idling patterns, and
// groups that run past the declared size. Every output transaction is
// checked against an in-bench model of the 4 KiB history ring decoder.
// ------------------------------------------------------------------------
module tb_lz77_type10_decompressor_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RING_SIZE   = 4096;
	localparam int unsigned MAX_MATCH   = 18;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef enum bit [2:0] {
		DP_TYPE,
		DP_SIZE_LO,
		DP_SIZE_MI,
		DP_SIZE_HI,
		DP_UNIT,
		DP_TOKEN_LO
	} dec_phase_t;

	typedef struct packed {
		bit [7:0] byte_val;
		bit       run_end;
		bit       size_hit;
	} out_beat_t;

	logic clk;
	logic arst_n;

	lzt_in_if  cin();
	lzt_out_if cout();

	lz77_type10_decompressor_unit #(
		.RING_SIZE(RING_SIZE),
		.MAX_MATCH(MAX_MATCH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.compressed(cin),
		.decompressed(cout)
	);

	// Decoder model state.
	bit [7:0]   hist_ring [RING_SIZE];
	bit [11:0]  ring_wptr;
	bit [7:0]   flag_reg;
	bit [3:0]   units_left;
	dec_phase_t dec_phase;
	bit [7:0]   token_hi;
	bit [23:0]  declared_size;
	bit [23:0]  produced_count;

	out_beat_t  expected_bytes[$];
	out_beat_t  want;
	bit [23:0]  planned_size;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned bytes_sent;
	int unsigned mismatches;
	int unsigned cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_decoder();
		for (int i = 0; i < RING_SIZE; i++) begin
			hist_ring[i] = (i >= RING_SIZE - MAX_MATCH) ?
				lzt_pkg::ZERO_BYTE : lzt_pkg::FILL_BYTE;
		end
		ring_wptr      = 12'(RING_SIZE - MAX_MATCH);
		flag_reg       = '0;
		units_left     = '0;
		dec_phase      = DP_TYPE;
		token_hi       = '0;
		declared_size  = '0;
		produced_count = '0;
	endfunction

	// Every decoded byte goes into the ring; it is only expected on the
	// output while the declared size has not been reached.
	function automatic void ring_put(input bit [7:0] c);
		out_beat_t beat;
		hist_ring[ring_wptr] = c;
		ring_wptr = ring_wptr + 12'd1;
		if (produced_count < declared_size) begin
			produced_count = produced_count + 24'd1;
			beat.byte_val = c;
			beat.run_end  = 1'b0;
			beat.size_hit = (produced_count == declared_size);
			expected_bytes.push_back(beat);
		end
	endfunction

	function automatic void advance_unit();
		flag_reg = flag_reg << 1;
		if (units_left != 0)
			units_left = units_left - 4'd1;
	endfunction

	function automatic void decode_byte(input bit [7:0] b);
		int unsigned queued_before;
		int unsigned copy_len;
		bit [11:0]   offset;
		bit [11:0]   src;
		out_beat_t   tail;
		queued_before = expected_bytes.size();
		case (dec_phase)
			DP_TYPE: begin
				dec_phase = DP_SIZE_LO;
			end
			DP_SIZE_LO: begin
				declared_size[7:0] = b;
				dec_phase = DP_SIZE_MI;
			end
			DP_SIZE_MI: begin
				declared_size[15:8] = b;
				dec_phase = DP_SIZE_HI;
			end
			DP_SIZE_HI: begin
				declared_size[23:16] = b;
				dec_phase = DP_UNIT;
			end
			DP_TOKEN_LO: begin
				offset   = {token_hi[3:0], b};
				copy_len = token_hi[7:4] + lzt_pkg::THRESHOLD + 1;
				// Source is re-read each byte, so a short offset repeats the
				// bytes just written.
				for (int k = 0; k < copy_len; k++) begin
					src = ring_wptr - offset - 12'd1;
					ring_put(hist_ring[src]);
				end
				advance_unit();
				dec_phase = DP_UNIT;
			end
			default: begin
				if (units_left == 0) begin
					flag_reg   = b;
					units_left = lzt_pkg::GROUP_UNITS;
				end else if (!flag_reg[7]) begin
					ring_put(b);
					advance_unit();
				end else begin
					token_hi  = b;
					dec_phase = DP_TOKEN_LO;
				end
			end
		endcase
		if (expected_bytes.size() > queued_before) begin
			tail = expected_bytes.pop_back();
			tail.run_end = 1'b1;
			expected_bytes.push_back(tail);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_byte(input bit [7:0] b);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			cin.valid <= 1'b0;
			@(negedge clk);
		end
		cin.valid   <= 1'b1;
		cin.in_byte <= b;
		@(posedge clk);
		while (!cin.ready)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	// One flag byte and its eight units. Offsets are short (0 to 31) half of the time
	// at random, so that copies can overlap their own output.
	task automatic send_group();
		bit [7:0]  flags;
		bit [11:0] offset;
		flags = 8'($urandom);
		send_byte(flags);
		for (int i = 7; i >= 0; i--) begin
			if (flags[i]) begin
				if ($urandom_range(1, 0) == 0)
					offset = 12'($urandom_range(31, 0));
				else
					offset = 12'($urandom);
				send_byte({4'($urandom), offset[11:8]});
				send_byte(offset[7:0]);
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	task automatic test_directed_extremes();
		bit [7:0] dir_bytes[$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		dir_bytes = '{8'h10, planned_size[7:0], planned_size[15:8], planned_size[23:16],
			// All literals, field extremes and alternating bits.
			8'h00, 8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe,
			// Longest copy from the farthest offset, shortest copy at offset
			// zero, longest self-overlapping copy, a short copy of recent
			// output, then four literals.
			8'hf0, 8'hff, 8'hff, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h13,
			8'h3c, 8'hc3, 8'h96, 8'h69};
		foreach (dir_bytes[i])
			send_byte(dir_bytes[i]);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
		input int unsigned n_bytes);
		int unsigned target;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target)
			send_group();
	endtask

	// Runs the stream up to the declared size and on past it, where the
	// ring keeps updating but nothing more may come out.
	task automatic test_past_declared_size();
		send_idle_pct  = 38;
		recv_stall_pct = 38;
		while (produced_count < declared_size)
			send_group();
		repeat (3)
			send_group();
	endtask

	always @(negedge clk)
		cout.ready <= ($urandom_range(99, 0) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && cout.valid && cout.ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h", cout.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (cout.out_byte !== want.byte_val)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						cout.out_byte, want.byte_val));
				if (cout.last_of_run !== want.run_end)
					report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
						cout.last_of_run, want.run_end, want.byte_val));
				if (cout.stream_done !== want.size_hit)
					report_mismatch($sformatf("stream_done %b, expected %b on byte %02h",
						cout.stream_done, want.size_hit, want.byte_val));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cin.valid      = 1'b0;
		cin.in_byte    = '0;
		cout.ready     = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_sent     = 0;
		mismatches     = 0;
		cycle_count    = 0;
		// Large enough that the random phases stay below it, so the size is
		// reached in the final phase.
		planned_size   = 24'($urandom_range(1900, 1700));
		reset_decoder();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_random_traffic(0, 0, 100);
		test_random_traffic(50, 0, 100);
		test_random_traffic(0, 50, 100);
		test_random_traffic(38, 38, 100);
		test_past_declared_size();

		@(negedge clk);
		cin.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4 * MAX_MATCH) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/lzt_pkg.sv
sv/lzt_if.sv
sv/lz77_type10_decompressor_unit.sv
bench/tb_lz77_type10_decompressor_unit.sv
